>>> rtl/core/zrle_pkg.sv
// Shared constants, scan table and controller/datapath link types for the
// zigzag run-length block encoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package zrle_pkg;

   localparam int COEF_W     = 16;
   localparam int CODE_W     = 24;
   localparam int CODE_LEN_W = 5;
   localparam int DROP_W     = 4;
   localparam int ADDR_W     = 6;
   localparam int RUN_BITS   = 6;
   localparam int LEN_BITS   = 4;
   localparam int LEN_MAX    = 13;
   localparam int DC_BITS    = 12;
   localparam int DC_LIMIT   = 2040;

   localparam logic [ADDR_W-1:0] LAST_INDEX = ADDR_W'(63);

   // Zigzag scan: scan position -> row-major store address
   localparam logic [ADDR_W-1:0] SCAN_ORDER [64] = '{
       6'd0,  6'd1,  6'd8, 6'd16,  6'd9,  6'd2,  6'd3, 6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11,  6'd4,  6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13,  6'd6,  6'd7, 6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   // Controller -> datapath commands
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              emit;
      logic              is_dc;
      logic              is_end;
      logic              run_clear;
      logic              run_inc;
   } zrle_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic coef_zero;
      logic out_free;
   } zrle_status_type;

endpackage

`default_nettype wire

>>> rtl/core/zrle_req_if.sv
// Input channel of the encoder: one coefficient per beat.
// Depends on zrle_pkg for the coefficient width.
`timescale 1ns / 1ps
`default_nettype none

interface zrle_req_if
   import zrle_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [COEF_W-1:0] coefficient;

   modport source (output valid, output coefficient, input ready);
   modport sink   (input valid, input coefficient, output ready);
endinterface

`default_nettype wire

>>> rtl/core/zrle_rsp_if.sv
// Result channel of the encoder: one code word per beat.
// Depends on zrle_pkg for the code widths.
`timescale 1ns / 1ps
`default_nettype none

interface zrle_rsp_if
   import zrle_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [CODE_W-1:0]     code;
   logic [CODE_LEN_W-1:0] code_length;
   logic                  last;

   modport source (output valid, output code, output code_length, output last, input ready);
   modport sink   (input valid, input code, input code_length, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/zrle_ctrl.sv
// Encoder controller: load/scan state machine, load counter, scan position.
// Depends on zrle_pkg for the command/status types and the zigzag table.
`timescale 1ns / 1ps
`default_nettype none

module zrle_ctrl
   import zrle_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire zrle_status_type status,
   output zrle_cmd_type         cmd
);

   localparam logic ST_LOAD = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic              state_ff, state_in;
   logic [ADDR_W-1:0] load_count_ff, load_count_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              need_emit;
   logic              advance;

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      pos_in        = pos_ff;
      req_ready     = 1'b0;
      need_emit     = 1'b0;
      advance       = 1'b0;

      cmd           = '0;
      cmd.wr_addr   = load_count_ff;
      cmd.is_dc     = (pos_ff == '0);
      cmd.is_end    = (pos_ff == LAST_INDEX);

      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.wr_en     = 1'b1;
               load_count_in = load_count_ff + ADDR_W'(1);
               // final beat of the block: prefetch the DC term
               if (load_count_ff == LAST_INDEX) begin
                  state_in    = ST_SCAN;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = SCAN_ORDER[0];
                  pos_in      = '0;
               end
            end
         end
         ST_SCAN: begin
            // DC and the last position always produce a code word
            need_emit = cmd.is_dc || cmd.is_end || !status.coef_zero;
            advance   = !need_emit || status.out_free;
            cmd.emit  = need_emit && status.out_free;
            if (advance) begin
               if (cmd.is_dc || !status.coef_zero || cmd.is_end) begin
                  cmd.run_clear = 1'b1;
               end else begin
                  cmd.run_inc = 1'b1;
               end
               if (cmd.is_end) begin
                  state_in = ST_LOAD;
                  pos_in   = '0;
               end else begin
                  pos_in      = pos_ff + ADDR_W'(1);
                  cmd.rd_en   = 1'b1;
                  cmd.rd_addr = SCAN_ORDER[pos_ff + ADDR_W'(1)];
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
         pos_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         pos_ff        <= pos_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/zrle_datapath.sv
// Encoder datapath: drop-factor register, coefficient store, zero-run counter,
// code word builder and output register. Depends on zrle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module zrle_datapath
   import zrle_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire zrle_cmd_type             cmd,
   output zrle_status_type               status,
   input  wire logic signed [COEF_W-1:0] coefficient,
   input  wire logic                     csr_wr_en,
   input  wire logic [DROP_W-1:0]        csr_wr_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [CODE_W-1:0]             rsp_code,
   output logic [CODE_LEN_W-1:0]         rsp_code_length,
   output logic                          rsp_last
);

   localparam logic signed [COEF_W-1:0] DC_HI = COEF_W'(DC_LIMIT);
   localparam logic signed [COEF_W-1:0] DC_LO = -DC_HI;

   logic [DROP_W-1:0]     drop_factor_ff;
   logic [COEF_W-1:0]     coef_store_ff [64];
   logic [COEF_W-1:0]     rd_data_ff;
   logic [RUN_BITS-1:0]   run_ff, run_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic [CODE_LEN_W-1:0] rsp_code_length_ff, rsp_code_length_in;
   logic                  rsp_last_ff;

   logic [3:0]               diag_sum;
   logic [3:0]               weight;
   logic [COEF_W-1:0]        wr_data;
   logic signed [COEF_W-1:0] coef_s;
   logic [COEF_W-1:0]        mag;
   logic [LEN_BITS-1:0]      nbits;
   logic [LEN_BITS-1:0]      len;
   logic signed [COEF_W-1:0] dc_clamped;
   logic [CODE_W-1:0]        val_mask;
   logic [CODE_W-1:0]        val_bits;
   logic [CODE_W-1:0]        prefix;
   logic [RUN_BITS-1:0]      run_plus;

   // Drop coefficients on the triangular threshold as they arrive
   always_comb begin
      diag_sum = {1'b0, cmd.wr_addr[5:3]} + {1'b0, cmd.wr_addr[2:0]};
      weight   = 4'd15 - diag_sum;
      wr_data  = (weight <= drop_factor_ff) ? '0 : coefficient;
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_factor_ff <= '0;
      end else if (csr_wr_en) begin
         drop_factor_ff <= csr_wr_data;
      end
   end

   // Coefficient store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         coef_store_ff[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= coef_store_ff[cmd.rd_addr];
      end
   end

   // Zero-run counter
   always_comb begin
      run_in = run_ff;
      if (cmd.run_clear) begin
         run_in = '0;
      end else if (cmd.run_inc) begin
         run_in = run_ff + RUN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else begin
         run_ff <= run_in;
      end
   end

   // Signed bit length of the current coefficient, clamped to LEN_MAX
   always_comb begin
      coef_s = $signed(rd_data_ff);
      mag    = rd_data_ff[COEF_W-1] ? ~rd_data_ff : rd_data_ff;
      nbits  = '0;
      for (int i = 0; i < COEF_W - 1; i++) begin
         if (mag[i]) begin
            nbits = LEN_BITS'(i + 1);
         end
      end
      if (nbits >= LEN_BITS'(LEN_MAX - 1)) begin
         len = LEN_BITS'(LEN_MAX);
      end else begin
         len = nbits + LEN_BITS'(1);
      end
   end

   // Build the code word for the current scan position
   always_comb begin
      if (coef_s > DC_HI) begin
         dc_clamped = DC_HI;
      end else if (coef_s < DC_LO) begin
         dc_clamped = DC_LO;
      end else begin
         dc_clamped = coef_s;
      end

      val_mask = (CODE_W'(1) << len) - CODE_W'(1);
      val_bits = CODE_W'(rd_data_ff) & val_mask;
      run_plus = run_ff + RUN_BITS'(1);

      if (run_ff != '0) begin
         prefix = CODE_W'({run_ff, len});
      end else begin
         prefix = CODE_W'({1'b1, len});
      end

      if (cmd.is_dc) begin
         rsp_code_in        = CODE_W'(dc_clamped[DC_BITS-1:0]);
         rsp_code_length_in = CODE_LEN_W'(DC_BITS);
      end else if (status.coef_zero) begin
         // zero run up to the block end
         rsp_code_in        = CODE_W'(run_plus);
         rsp_code_length_in = CODE_LEN_W'(RUN_BITS + 1);
      end else if (run_ff != '0) begin
         rsp_code_in        = (prefix << len) | val_bits;
         rsp_code_length_in = CODE_LEN_W'(RUN_BITS + LEN_BITS + 1) + CODE_LEN_W'(len);
      end else begin
         rsp_code_in        = (prefix << len) | val_bits;
         rsp_code_length_in = CODE_LEN_W'(LEN_BITS + 1) + CODE_LEN_W'(len);
      end
   end

   assign status.coef_zero = (rd_data_ff == '0);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Output register: load on emit, drop on a taken beat
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_code_ff        <= rsp_code_in;
         rsp_code_length_ff <= rsp_code_length_in;
         rsp_last_ff        <= cmd.is_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code        = rsp_code_ff;
   assign rsp_code_length = rsp_code_length_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/zigzag_rle_block_encoder_core.sv
// Zigzag run-length block encoder, top level: joins controller and datapath.
// Depends on zrle_pkg, zrle_req_if, zrle_rsp_if, zrle_ctrl, zrle_datapath.
//
// Usage:
//   req_bus carries one 16-bit signed coefficient per beat, 64 beats per 8x8
//   block in row-major order. rsp_bus carries code words (code, code_length,
//   last); last marks the final word of a block. csr_wr_en/csr_wr_data write
//   the 4-bit drop factor, which applies to coefficients that arrive later.
//   Timing: coefficients load at one per cycle. After the 64th beat the
//   input closes and the scan walks the 64 zigzag positions at one per cycle,
//   waiting where a code word is due and the output register is full, through
//   the store's registered read port; the 64th beat prefetches the DC term into
//   the read register, and the DC code word then enters the output register.
//   Throughput is set by the one coefficient store, which cannot take a new
//   block while the current one is scanned.
//   Input reopens the cycle after the last code word enters the output reg.
//   A stalled receiver holds the output register; the scan waits at any
//   position that must emit, and skips zero positions meanwhile.
//   Reset (synchronous, active high) clears the drop factor, counters and
//   output valid; the coefficient store is not cleared and needs none.
`timescale 1ns / 1ps
`default_nettype none

module zigzag_rle_block_encoder_core
   import zrle_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   zrle_req_if.sink               req_bus,
   zrle_rsp_if.source             rsp_bus,
   input  wire logic              csr_wr_en,
   input  wire logic [DROP_W-1:0] csr_wr_data
);

   zrle_cmd_type    cmd;
   zrle_status_type status;
   logic            req_ready;
   logic            rsp_valid;
   logic [CODE_W-1:0]     rsp_code;
   logic [CODE_LEN_W-1:0] rsp_code_length;
   logic            rsp_last;

   // Sequence load and scan
   zrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Store coefficients and build code words
   zrle_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .coefficient     (req_bus.coefficient),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_code        (rsp_code),
      .rsp_code_length (rsp_code_length),
      .rsp_last        (rsp_last)
   );

   assign req_bus.ready       = req_ready;
   assign rsp_bus.valid       = rsp_valid;
   assign rsp_bus.code        = rsp_code;
   assign rsp_bus.code_length = rsp_code_length;
   assign rsp_bus.last        = rsp_last;

`ifndef SYNTHESIS
   // A code word is only loaded when the output register can take it
   a_emit_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("code word loaded over an untaken beat");

   // The final code word of a block reopens the input
   a_end_reopens: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.is_end) |=> req_bus.ready)
      else $error("input not reopened after block end");

   // The prefetch on the final load beat never hits the entry being written
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && cmd.rd_en) |-> (cmd.wr_addr != cmd.rd_addr))
      else $error("store read and write at the same address");

   // Nothing is emitted while coefficients are loading
   a_no_emit_in_load: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !cmd.emit)
      else $error("code word emitted during load");
`endif

endmodule

`default_nettype wire

>>> dv/tb_zigzag_rle_block_encoder_core.sv
// Self-checking testbench for the zigzag run-length block encoder core.
// Depends on zrle_pkg, zrle_req_if, zrle_rsp_if and zigzag_rle_block_encoder_core.
// Drives whole 8x8 blocks and checks every code word against a local block coder or typed expected words.
`timescale 1ns / 1ps

module tb_zigzag_rle_block_encoder_core;
   import zrle_pkg::*;

   localparam int QUIET_LIMIT  = 2000;
   localparam int NO_TYPED_DC  = -1;
   localparam int NO_MID_WRITE = -1;
   localparam int RANDOM_BLOCKS = 1;
   localparam int TAIL_ITEMS   = 24;
   localparam int PHASE_ITEMS  = 93;
   localparam int END_RUN_WORD = 63;

   typedef enum {FILL_CONST, FILL_SPARSE, FILL_TAIL, FILL_RANDOM} fill_kind_type;

   // One directed block: fill pattern, drop factor, optional mid-block write,
   // and the DC word where the whole output is known by inspection.
   typedef struct {
      fill_kind_type kind;
      int            dc;
      int            fill;
      int            drop;
      int            mid_at;
      int            mid_drop;
      int            dc_word;
   } block_row_type;

   typedef struct packed {
      logic [CODE_W-1:0]     code;
      logic [CODE_LEN_W-1:0] code_length;
      logic                  last;
   } code_beat_type;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [DROP_W-1:0]   csr_wr_data;

   zrle_req_if req_bus ();
   zrle_rsp_if rsp_bus ();

   zigzag_rle_block_encoder_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Encoder image: store, load counter and drop factor as the block sees them
   logic signed [COEF_W-1:0] block_image [64];
   int                       load_index;
   int                       drop_model;
   int                       zigzag_addr [64];

   code_beat_type expected_codes [$];
   int            typed_dc_words [$];
   logic signed [COEF_W-1:0] block_buf [64];

   int mismatches;
   int quiet_cycles;
   int items_sent;
   int send_idle_pct;
   int recv_stall_pct;

   block_row_type directed_rows [3] = '{
      '{FILL_CONST,   32767,      0,  0, NO_MID_WRITE, 0, 12'h7F8},
      '{FILL_RANDOM,      0,      0, 15, NO_MID_WRITE, 0, 12'h000},
      '{FILL_TAIL,   -32768, -32768,  3,           31, 0, NO_TYPED_DC}
   };

   // Clock: 4 ns period
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Fill the zigzag scan: odd diagonals walk down the rows, even ones up
   function automatic void build_zigzag();
      int pos;
      int lo;
      int hi;
      pos = 0;
      for (int s = 0; s < 15; s++) begin
         lo = (s > 7) ? s - 7 : 0;
         hi = (s < 7) ? s : 7;
         if (s % 2 == 1) begin
            for (int u = lo; u <= hi; u++) begin
               zigzag_addr[pos] = u * 8 + (s - u);
               pos++;
            end
         end else begin
            for (int u = hi; u >= lo; u--) begin
               zigzag_addr[pos] = u * 8 + (s - u);
               pos++;
            end
         end
      end
   endfunction

   // Signed bit length, sign bit included, saturated at the maximum length
   function automatic int signed_bits(int value);
      int mag;
      int n;
      mag = (value >= 0) ? value : -value - 1;
      n = 1;
      while (mag != 0) begin
         n++;
         mag = mag >> 1;
      end
      if (n > LEN_MAX) n = LEN_MAX;
      return n;
   endfunction

   // Code a full block: DC word, then zero runs and values in zigzag order
   function automatic void predict_block();
      code_beat_type words [$];
      int dc;
      int run;
      int c;
      int len;
      int val;
      int dc_word;
      dc_word = (typed_dc_words.size() != 0) ? typed_dc_words.pop_front() : NO_TYPED_DC;
      if (dc_word != NO_TYPED_DC) begin
         words.insert(words.size(),
            code_beat_type'{CODE_W'(dc_word), CODE_LEN_W'(DC_BITS), 1'b0});
         words.insert(words.size(),
            code_beat_type'{CODE_W'(END_RUN_WORD), CODE_LEN_W'(1 + RUN_BITS), 1'b0});
      end else begin
         dc = block_image[0];
         if (dc > DC_LIMIT) dc = DC_LIMIT;
         if (dc < -DC_LIMIT) dc = -DC_LIMIT;
         words.insert(words.size(),
            code_beat_type'{CODE_W'(dc & 'hFFF), CODE_LEN_W'(DC_BITS), 1'b0});
         run = 0;
         for (int pos = 1; pos < 64; pos++) begin
            c = block_image[zigzag_addr[pos]];
            if (c == 0) begin
               run++;
               if (pos == 63) begin
                  words.insert(words.size(),
                     code_beat_type'{CODE_W'(run), CODE_LEN_W'(1 + RUN_BITS), 1'b0});
               end
            end else begin
               len = signed_bits(c);
               val = c & ((1 << len) - 1);
               if (run > 0) begin
                  words.insert(words.size(), code_beat_type'{
                     CODE_W'((run << (LEN_BITS + len)) | (len << len) | val),
                     CODE_LEN_W'(1 + RUN_BITS + LEN_BITS + len), 1'b0});
               end else begin
                  words.insert(words.size(), code_beat_type'{
                     CODE_W'((1 << (LEN_BITS + len)) | (len << len) | val),
                     CODE_LEN_W'(1 + LEN_BITS + len), 1'b0});
               end
               run = 0;
            end
         end
      end
      words[words.size() - 1].last = 1'b1;
      foreach (words[i]) expected_codes.insert(expected_codes.size(), words[i]);
   endfunction

   // Load one accepted coefficient; zero it at or below the triangular threshold
   function automatic void load_coefficient(logic signed [COEF_W-1:0] value);
      int u;
      int v;
      u = load_index / 8;
      v = load_index % 8;
      if (15 - (u + v) <= drop_model) value = '0;
      block_image[load_index] = value;
      load_index++;
      if (load_index == 64) begin
         load_index = 0;
         predict_block();
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   // Monitor: track config writes, predict on input beats, check output beats
   always @(posedge clock) begin
      code_beat_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) drop_model = csr_wr_data;
         if (req_bus.valid && req_bus.ready) load_coefficient(req_bus.coefficient);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("unexpected code %h len %0d last %b",
                  rsp_bus.code, rsp_bus.code_length, rsp_bus.last));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_bus.code !== want.code)
                  report_mismatch($sformatf("code %h, want %h", rsp_bus.code, want.code));
               if (rsp_bus.code_length !== want.code_length)
                  report_mismatch($sformatf("code_length %0d, want %0d",
                     rsp_bus.code_length, want.code_length));
               if (rsp_bus.last !== want.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_bus.last, want.last));
            end
         end
         // Watchdog: count cycles without any beat
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // Receiver: stall at random
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offer one coefficient after a random gap and hold it until accepted; the idle
   // and stall mix moves on after PHASE_ITEMS and again after 2 * PHASE_ITEMS coefficients
   task automatic send_coefficient(logic signed [COEF_W-1:0] value);
      if (items_sent < PHASE_ITEMS) begin
         send_idle_pct  = 11;
         recv_stall_pct = 56;
      end else if (items_sent < 2 * PHASE_ITEMS) begin
         send_idle_pct  = 56;
         recv_stall_pct = 11;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
      items_sent++;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.coefficient <= value;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Write the drop factor once no code word is outstanding
   task automatic write_drop_factor(int value);
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_codes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= DROP_W'(value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Send block_buf as one block
   task automatic send_block(int dc_word, int mid_at, int mid_drop);
      typed_dc_words.insert(typed_dc_words.size(), dc_word);
      for (int k = 0; k < 64; k++) begin
         send_coefficient(block_buf[k]);
         if (k == mid_at) write_drop_factor(mid_drop);
      end
   endtask

   // Mostly zeros, then small, medium and full-range values
   function automatic logic signed [COEF_W-1:0] random_coefficient();
      int pick;
      pick = $urandom_range(99);
      if (pick < 55) return '0;
      if (pick < 80) return COEF_W'(int'($urandom_range(62)) - 31);
      if (pick < 92) return COEF_W'(int'($urandom_range(4095)) - 2048);
      return COEF_W'($urandom());
   endfunction

   initial begin
      block_row_type row;
      int mid_at;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.coefficient = '0;
      rsp_bus.ready       = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      load_index          = 0;
      drop_model          = 0;
      mismatches          = 0;
      quiet_cycles        = 0;
      items_sent          = 0;
      send_idle_pct       = 11;
      recv_stall_pct      = 56;
      foreach (block_image[i]) block_image[i] = '0;
      build_zigzag();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed blocks
      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         for (int k = 0; k < 64; k++) begin
            case (row.kind)
               FILL_CONST:  block_buf[k] = (k == 0) ? COEF_W'(row.dc) : COEF_W'(row.fill);
               FILL_SPARSE: block_buf[k] = (k == 0) ? COEF_W'(row.dc) :
                                           (k % 5 == 3) ? COEF_W'(k * 37 - 1000) : '0;
               FILL_TAIL:   block_buf[k] = (k == 0) ? COEF_W'(row.dc) :
                                           (k == 63) ? COEF_W'(row.fill) : '0;
               default:     block_buf[k] = COEF_W'($urandom());
            endcase
         end
         write_drop_factor(row.drop);
         send_block(row.dc_word, row.mid_at, row.mid_drop);
      end

      // Random blocks: the first with drop factor zero, later ones random, some changed mid-block
      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         foreach (block_buf[k]) block_buf[k] = random_coefficient();
         if ($urandom_range(1) == 1) block_buf[0] = COEF_W'($urandom());
         write_drop_factor((b == 0) ? 0 : $urandom_range(15));
         mid_at = ($urandom_range(3) == 0) ? $urandom_range(1, 62) : NO_MID_WRITE;
         send_block(NO_TYPED_DC, mid_at, $urandom_range(15));
      end

      // Partial block: these beats must produce no code word
      for (int k = 0; k < TAIL_ITEMS; k++) begin
         send_coefficient(random_coefficient());
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      // Drain, then wait for stray words
      while (expected_codes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (expected_codes.size() != 0)
         report_mismatch($sformatf("%0d code words never arrived", expected_codes.size()));
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/zrle_pkg.sv
rtl/core/zrle_req_if.sv
rtl/core/zrle_rsp_if.sv
rtl/core/zrle_ctrl.sv
rtl/core/zrle_datapath.sv
rtl/core/zigzag_rle_block_encoder_core.sv
dv/tb_zigzag_rle_block_encoder_core.sv
